### src/itot_pkg.sv
// shared types, constants and table-building functions for the overcurrent trip block
// no dependencies
package itot_pkg;

	localparam int CHANNELS = 4;
	localparam int CURVE_TABLE_DEPTH_DEF = 256;
	localparam int OCTAVES = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_W = 44;
	localparam int DEN_W = 32;
	localparam int PROG_W = 26;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [31:0] M_MIN_Q16 = 32'd66191;
	localparam logic [63:0] EXPO_Q30 = 64'd21474836;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << 24;
	localparam logic [PROG_W-1:0] PROG_MAX = PROG_W'(1) << 25;
	localparam logic [7:0] CURVE_K = 8'd140;

	typedef enum logic [2:0] {
		REG_PICKUP      = 3'd0,
		REG_TIME_MULT   = 3'd1,
		REG_MIN_OPERATE = 3'd2,
		REG_MAX_OPERATE = 3'd3,
		REG_OP_DELAY    = 3'd4,
		REG_RESET_DELAY = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] current_ch0;
		logic [15:0] current_ch1;
		logic [15:0] current_ch2;
		logic [15:0] current_ch3;
		logic [15:0] elapsed_ms;
	} sample_t;

	typedef struct packed {
		logic       trip_active;
		logic       trip_set;
		logic       trip_cleared;
		logic [3:0] tripped_mask;
		logic [3:0] reset_mask;
	} result_t;

	typedef struct packed {
		logic [15:0] pickup_current;
		logic [15:0] time_multiplier;
		logic [15:0] min_operate_ms;
		logic [15:0] max_operate_ms;
		logic [15:0] operate_delay_ms;
		logic [15:0] reset_delay_ms;
	} cfg_t;

	// classified sample set handed from front to back
	typedef struct packed {
		logic [CHANNELS-1:0][15:0] current;
		logic [15:0]               delta;
		logic [CHANNELS-1:0]       above;
	} job_t;

	// truncating unsigned long division by shift and subtract, table building only
	function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(y) in q30 for small y, truncating series
	function automatic logic [63:0] exp_q30(input logic [63:0] y);
		logic [63:0] sum;
		logic [63:0] term;
		sum = Q30_ONE;
		term = Q30_ONE;
		for (int k = 1; k <= 10; k++) begin
			term = div_u64((term * y) >> 30, 64'(k));
			sum = sum + term;
		end
		return sum;
	endfunction

	// ln(f) in q30 for f in [1,2], atanh series
	function automatic logic [63:0] ln_q30(input logic [63:0] f);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] s;
		z = div_u64((f - Q30_ONE) << 30, f + Q30_ONE);
		z2 = (z * z) >> 30;
		p = z;
		s = 64'd0;
		for (int n = 1; n <= 21; n += 2) begin
			s = s + div_u64(p, 64'(n));
			p = (p * z2) >> 30;
		end
		return s << 1;
	endfunction

	// per-octave factor 2^(0.02*oct) in q30
	function automatic logic [30:0] oct_entry(input int k);
		return 31'(exp_q30((64'(k) * LN2_Q30 * EXPO_Q30) >> 30));
	endfunction

endpackage

### src/itot_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on itot_pkg
module itot_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [itot_pkg::DIV_W-1:0] num,
	input  logic [itot_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [itot_pkg::DIV_W-1:0] quo
);
	import itot_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             take;

	// one shift-subtract step
	assign trial = {rem_q[DEN_W-1:0], num_q[DIV_W-1]};
	assign take = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? trial - {1'b0, den_q} : trial;
			num_q <= {num_q[DIV_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo = num_q;

endmodule

### src/itot_queue.sv
// short queue of classified sample sets between front and back
// depends on itot_pkg
module itot_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  itot_pkg::job_t   push_job,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output itot_pkg::job_t   head
);
	import itot_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && !full |=> not_empty)
		else $error("queue lost a request");

endmodule

### src/itot_front.sv
// front end: takes sample requests and marks channels above pickup
// depends on itot_pkg
module itot_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  itot_pkg::sample_t sample,
	input  logic [15:0]       pickup_current,
	output logic              push,
	output itot_pkg::job_t    push_job,
	input  logic              queue_full
);
	import itot_pkg::*;

	logic [15:0] pick;
	job_t        job_d;
	job_t        job_q;
	logic        valid_q;
	logic        accept;

	// zero pickup acts as one
	assign pick = (pickup_current == 16'd0) ? 16'd1 : pickup_current;

	always_comb begin
		job_d.current[0] = sample.current_ch0;
		job_d.current[1] = sample.current_ch1;
		job_d.current[2] = sample.current_ch2;
		job_d.current[3] = sample.current_ch3;
		job_d.delta = sample.elapsed_ms;
		for (int c = 0; c < CHANNELS; c++) begin
			job_d.above[c] = job_d.current[c] > pick;
		end
	end

	assign push = valid_q && !queue_full;
	assign sample_ready = !valid_q || push;
	assign accept = sample_valid && sample_ready;
	assign push_job = job_q;

	// holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q <= job_d;
		end
	end

endmodule

### src/itot_back.sv
// back end: per-channel curve evaluation, progress integration and trip decision
// depends on itot_pkg and itot_div
module itot_back #(
	parameter int CURVE_TABLE_DEPTH = itot_pkg::CURVE_TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  itot_pkg::cfg_t    cfg,
	input  logic              job_valid,
	input  itot_pkg::job_t    job,
	output logic              job_pop,
	output logic              result_valid,
	input  logic              result_ready,
	output itot_pkg::result_t result
);
	import itot_pkg::*;

	localparam int DB = $clog2(CURVE_TABLE_DEPTH);
	localparam int IDX_W = $clog2(CURVE_TABLE_DEPTH + 1);
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef logic [30:0] mant_tab_t [CURVE_TABLE_DEPTH+1];
	typedef logic [30:0] oct_tab_t [OCTAVES];

	function automatic mant_tab_t build_mant();
		mant_tab_t   t;
		logic [63:0] f;
		for (int k = 0; k <= CURVE_TABLE_DEPTH; k++) begin
			f = Q30_ONE + div_u64(64'(k) << 30, 64'(CURVE_TABLE_DEPTH));
			t[k] = 31'(exp_q30((ln_q30(f) * EXPO_Q30) >> 30));
		end
		return t;
	endfunction

	function automatic oct_tab_t build_oct();
		oct_tab_t t;
		for (int k = 0; k < OCTAVES; k++) begin
			t[k] = oct_entry(k);
		end
		return t;
	endfunction

	localparam mant_tab_t MANT = build_mant();
	localparam oct_tab_t OCT = build_oct();

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_CHAN   = 13'b0000000000010,
		ST_DIVM   = 13'b0000000000100,
		ST_NORM   = 13'b0000000001000,
		ST_INTERP = 13'b0000000010000,
		ST_SCALE  = 13'b0000000100000,
		ST_DEN    = 13'b0000001000000,
		ST_DIVT   = 13'b0000010000000,
		ST_OPER   = 13'b0000100000000,
		ST_DIVS   = 13'b0001000000000,
		ST_ACC    = 13'b0010000000000,
		ST_NEXT   = 13'b0100000000000,
		ST_FIN    = 13'b1000000000000
	} state_t;

	state_t              state_q;
	logic [CH_W-1:0]     ch_q;
	logic [PROG_W-1:0]   prog_q [CHANNELS];
	logic [15:0]         rel_q [CHANNELS];
	logic                flag_q;
	logic [CHANNELS-1:0] tmask_q;
	logic [CHANNELS-1:0] rmask_q;
	logic [31:0]         mq_q;
	logic [3:0]          oct_q;
	logic [29:0]         frac_q;
	logic [60:0]         prod_q;
	logic [30:0]         m0_q;
	logic [61:0]         pw_q;
	logic [DIV_W-1:0]    quo_q;
	logic                result_valid_q;
	result_t             result_q;

	logic                div_start;
	logic [DIV_W-1:0]    div_num;
	logic [DEN_W-1:0]    div_den;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;

	logic [15:0]         cur;
	logic [15:0]         pick;
	logic                last_ch;
	logic [4:0]          msb;
	logic [31:0]         norm;
	logic [29+DB:0]      pos;
	logic [IDX_W-1:0]    k_idx;
	logic [IDX_W-1:0]    k1_idx;
	logic [29:0]         w;
	logic [30:0]         diff;
	logic [30:0]         v;
	logic [31:0]         pw_hi;
	logic [31:0]         den_d;
	logic [DIV_W:0]      op_sum;
	logic [15:0]         op;
	logic [16:0]         r_sum;
	logic [15:0]         r_sat;
	logic [DIV_W:0]      prog_sum;
	logic [PROG_W-1:0]   prog_new;
	logic                now;
	logic                out_free;

	itot_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cur = job.current[ch_q];
	assign pick = (cfg.pickup_current == 16'd0) ? 16'd1 : cfg.pickup_current;
	assign last_ch = ch_q == CH_W'(CHANNELS - 1);
	assign out_free = !result_valid_q || result_ready;

	// octave and mantissa of the pickup multiple
	always_comb begin
		msb = 5'd16;
		for (int b = 17; b <= 31; b++) begin
			if (mq_q[b]) begin
				msb = 5'(b);
			end
		end
		norm = mq_q << (5'd31 - msb);
	end

	// table interpolation terms: segment index from bit 30 up, weight below
	assign pos = (30+DB)'(frac_q) * (30+DB)'(CURVE_TABLE_DEPTH);
	assign k_idx = IDX_W'(pos[29+DB:30]);
	assign k1_idx = k_idx + IDX_W'(1);
	assign w = pos[29:0];
	assign diff = MANT[k1_idx] - MANT[k_idx];
	assign v = m0_q + prod_q[60:30];
	assign pw_hi = pw_q[61:30];
	assign den_d = (pw_hi > 32'(Q30_ONE)) ? pw_hi - 32'(Q30_ONE) : 32'd1;

	// operate time: add delay, clamp min then max, never zero
	always_comb begin
		op_sum = {1'b0, quo_q} + (DIV_W+1)'(cfg.operate_delay_ms);
		if (op_sum < (DIV_W+1)'(cfg.min_operate_ms)) begin
			op_sum = (DIV_W+1)'(cfg.min_operate_ms);
		end
		if (op_sum > (DIV_W+1)'(cfg.max_operate_ms)) begin
			op_sum = (DIV_W+1)'(cfg.max_operate_ms);
		end
		op = (op_sum[15:0] == 16'd0) ? 16'd1 : op_sum[15:0];
	end

	// reset timer of a channel at or below pickup
	assign r_sum = {1'b0, rel_q[ch_q]} + {1'b0, job.delta};
	assign r_sat = r_sum[16] ? 16'hFFFF : r_sum[15:0];

	// progress accumulation with saturation at two
	assign prog_sum = (DIV_W+1)'(prog_q[ch_q]) + {1'b0, quo_q};
	assign prog_new = (prog_sum > (DIV_W+1)'(PROG_MAX)) ? PROG_MAX : prog_sum[PROG_W-1:0];

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		unique case (state_q)
			ST_CHAN: begin
				div_start = job.above[ch_q];
				div_num = DIV_W'({cur, 16'd0});
				div_den = DEN_W'(pick);
			end
			ST_DEN: begin
				div_start = 1'b1;
				div_num = DIV_W'({24'(cfg.time_multiplier) * 24'(CURVE_K), 20'd0});
				div_den = den_d;
			end
			ST_OPER: begin
				div_start = 1'b1;
				div_num = DIV_W'({job.delta, 24'd0});
				div_den = DEN_W'(op);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign now = (tmask_q != '0) ? 1'b1 : ((rmask_q != '0) ? 1'b0 : flag_q);
	assign job_pop = (state_q == ST_FIN) && out_free;

	// control sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q <= '0;
			flag_q <= 1'b0;
			tmask_q <= '0;
			rmask_q <= '0;
			result_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				prog_q[c] <= '0;
				rel_q[c] <= '0;
			end
		end else begin
			// output register: load on finish, drop once taken
			if (job_pop) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						ch_q <= '0;
						tmask_q <= '0;
						rmask_q <= '0;
						state_q <= ST_CHAN;
					end
				end
				ST_CHAN: begin
					if (job.above[ch_q]) begin
						rel_q[ch_q] <= '0;
						state_q <= ST_DIVM;
					end else begin
						if (r_sat >= cfg.reset_delay_ms) begin
							prog_q[ch_q] <= '0;
							rel_q[ch_q] <= '0;
							rmask_q[ch_q] <= 1'b1;
						end else begin
							rel_q[ch_q] <= r_sat;
						end
						state_q <= ST_NEXT;
					end
				end
				ST_DIVM: begin
					if (div_done) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM:   state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_DEN;
				ST_DEN:    state_q <= ST_DIVT;
				ST_DIVT: begin
					if (div_done) begin
						state_q <= ST_OPER;
					end
				end
				ST_OPER: state_q <= ST_DIVS;
				ST_DIVS: begin
					if (div_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					prog_q[ch_q] <= prog_new;
					if (prog_new >= PROG_ONE) begin
						tmask_q[ch_q] <= 1'b1;
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (last_ch) begin
						state_q <= ST_FIN;
					end else begin
						ch_q <= ch_q + CH_W'(1);
						state_q <= ST_CHAN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						flag_q <= now;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// curve datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_DIVM && div_done) begin
			mq_q <= (div_quo[31:0] < M_MIN_Q16) ? M_MIN_Q16 : div_quo[31:0];
		end
		if (state_q == ST_NORM) begin
			oct_q <= 4'(msb - 5'd16);
			frac_q <= norm[30:1];
		end
		if (state_q == ST_INTERP) begin
			prod_q <= 61'(diff) * 61'(w);
			m0_q <= MANT[k_idx];
		end
		if (state_q == ST_SCALE) begin
			pw_q <= 62'(OCT[oct_q]) * 62'(v);
		end
		if (div_done) begin
			quo_q <= div_quo;
		end
		if (state_q == ST_FIN && out_free) begin
			result_q.trip_active <= now;
			result_q.trip_set <= now && !flag_q;
			result_q.trip_cleared <= !now && flag_q;
			result_q.tripped_mask <= 4'(tmask_q);
			result_q.reset_mask <= 4'(rmask_q);
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	for (genvar g = 0; g < CHANNELS; g++) begin : g_prog_chk
		assert property (@(posedge clk) disable iff (!arst_n) prog_q[g] <= PROG_MAX)
			else $error("progress above saturation");
	end

	assert property (@(posedge clk) disable iff (!arst_n) (tmask_q & rmask_q) == '0)
		else $error("channel both tripped and reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.trip_set |-> result_q.trip_active)
		else $error("trip edge without trip");

	assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> result_valid_q && result_q.trip_active == flag_q)
		else $error("result does not follow trip flag");

endmodule

### src/inverse_time_overcurrent_trip.sv
// top level of the four-channel inverse-time overcurrent trip
// depends on itot_pkg, itot_front, itot_queue, itot_back
// Each sample request carries four current magnitudes and the elapsed ms; one result
// request comes back per sample with the trip flag, its edges and per-channel masks.
// The front register and a two-entry queue take new samples while the back end works.
// A channel at or below pickup skips the divider; a channel above pickup runs one shared
// 44-step divider three times (pickup multiple, curve time, progress step). A sample
// passes through the front register and the queue before the back end takes it.
// Configuration writes take effect at once and belong between samples.
module inverse_time_overcurrent_trip #(
	parameter int CURVE_TABLE_DEPTH = itot_pkg::CURVE_TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  itot_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output itot_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import itot_pkg::*;

	cfg_t cfg_q;
	logic push;
	job_t push_job;
	logic queue_full;
	logic job_valid;
	job_t job;
	logic job_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pickup_current <= 16'd100;
			cfg_q.time_multiplier <= 16'd102;
			cfg_q.min_operate_ms <= 16'd200;
			cfg_q.max_operate_ms <= 16'd800;
			cfg_q.operate_delay_ms <= 16'd100;
			cfg_q.reset_delay_ms <= 16'd500;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PICKUP:      cfg_q.pickup_current <= cfg_data;
				REG_TIME_MULT:   cfg_q.time_multiplier <= cfg_data;
				REG_MIN_OPERATE: cfg_q.min_operate_ms <= cfg_data;
				REG_MAX_OPERATE: cfg_q.max_operate_ms <= cfg_data;
				REG_OP_DELAY:    cfg_q.operate_delay_ms <= cfg_data;
				REG_RESET_DELAY: cfg_q.reset_delay_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	itot_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.pickup_current (cfg_q.pickup_current),
		.push           (push),
		.push_job       (push_job),
		.queue_full     (queue_full)
	);

	itot_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (job_pop),
		.not_empty (job_valid),
		.head      (job)
	);

	itot_back #(
		.CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.job_valid    (job_valid),
		.job          (job),
		.job_pop      (job_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### dv/itot_checker.sv
// checker for the inverse-time overcurrent trip: watches the sample, result and register ports,
// predicts every result and compares it field by field
// depends on itot_pkg
module itot_checker
	import itot_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        sample_ready,
	input  sample_t     sample,
	input  logic        result_valid,
	input  logic        result_ready,
	input  result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          trips_seen,
	output int          resets_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = CURVE_TABLE_DEPTH_DEF;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned POWER_Q30 = 64'd21474836;
	localparam longint unsigned LOG2_Q30 = 64'd744261118;
	localparam longint unsigned MULT_FLOOR = 64'd66191;
	localparam longint unsigned PROGRESS_ONE = 64'd1 << 24;
	localparam longint unsigned PROGRESS_CAP = 64'd1 << 25;

	longint unsigned pow_mant[DEPTH+1];
	longint unsigned pow_octave[16];

	logic [15:0] pickup, tms, op_min, op_max, op_delay, rst_delay;
	logic [25:0] progress[CHANNELS];
	logic [15:0] below_ms[CHANNELS];
	logic        tripped;
	result_t     expected_results[$];

	// truncating exp series in q30
	function automatic longint unsigned series_exp(longint unsigned y);
		longint unsigned acc;
		longint unsigned t;
		acc = ONE_Q30;
		t = ONE_Q30;
		for (int k = 1; k <= 10; k++) begin
			t = ((t * y) >> 30) / longint'(k);
			acc += t;
		end
		return acc;
	endfunction

	// natural log in q30 over [1,2], odd atanh series
	function automatic longint unsigned series_ln(longint unsigned f);
		longint unsigned z;
		longint unsigned z2;
		longint unsigned p;
		longint unsigned acc;
		z = ((f - ONE_Q30) << 30) / (f + ONE_Q30);
		z2 = (z * z) >> 30;
		p = z;
		acc = 0;
		for (int n = 1; n <= 21; n += 2) begin
			acc += p / longint'(n);
			p = (p * z2) >> 30;
		end
		return 2 * acc;
	endfunction

	initial begin
		for (int k = 0; k <= DEPTH; k++)
			pow_mant[k] = series_exp((series_ln(ONE_Q30 + (longint'(k) << 30) / DEPTH)
				* POWER_Q30) >> 30);
		for (int k = 0; k < 16; k++)
			pow_octave[k] = series_exp((longint'(k) * LOG2_Q30 * POWER_Q30) >> 30);
	end

	// multiple^0.02 - 1 in q30 from octave factor and interpolated mantissa table
	function automatic longint unsigned curve_den(longint unsigned mq);
		int msb;
		int oct;
		longint unsigned frac, pos, k, w, v, pw;
		msb = 16;
		while (msb < 31 && (mq >> (msb + 1)) != 0)
			msb++;
		oct = (msb - 16) & 15;
		frac = ((mq << 30) >> msb) - ONE_Q30;
		pos = frac * DEPTH;
		k = pos >> 30;
		if (k >= DEPTH)
			k = DEPTH - 1;
		w = pos & (ONE_Q30 - 1);
		v = pow_mant[k] + (((pow_mant[k+1] - pow_mant[k]) * w) >> 30);
		pw = (pow_octave[oct] * v) >> 30;
		return (pw > ONE_Q30) ? pw - ONE_Q30 : 1;
	endfunction

	// one sample set through the trip integrators
	function automatic result_t predict_trip(sample_t s);
		result_t r;
		longint unsigned cur[CHANNELS];
		longint unsigned pick, dt, mq, op, prog, el;
		logic [3:0] tmask, rmask;
		logic was;
		cur[0] = s.current_ch0;
		cur[1] = s.current_ch1;
		cur[2] = s.current_ch2;
		cur[3] = s.current_ch3;
		dt = s.elapsed_ms;
		pick = (pickup == 0) ? 1 : pickup;
		tmask = '0;
		rmask = '0;
		was = tripped;
		for (int c = 0; c < CHANNELS; c++) begin
			if (cur[c] > pick) begin
				below_ms[c] = '0;
				mq = (cur[c] << 16) / pick;
				if (mq < MULT_FLOOR)
					mq = MULT_FLOOR;
				op = (longint'(tms) * 140 * 1048576) / curve_den(mq) + op_delay;
				if (op < op_min)
					op = op_min;
				if (op > op_max)
					op = op_max;
				if (op == 0)
					op = 1;
				prog = progress[c] + (dt << 24) / op;
				if (prog > PROGRESS_CAP)
					prog = PROGRESS_CAP;
				progress[c] = prog[25:0];
				if (prog >= PROGRESS_ONE)
					tmask[c] = 1'b1;
			end else begin
				el = below_ms[c] + dt;
				if (el > 65535)
					el = 65535;
				if (el >= rst_delay) begin
					progress[c] = '0;
					el = 0;
					rmask[c] = 1'b1;
				end
				below_ms[c] = el[15:0];
			end
		end
		if (tmask != 0)
			tripped = 1'b1;
		else if (rmask != 0)
			tripped = 1'b0;
		r.trip_active = tripped;
		r.trip_set = tripped && !was;
		r.trip_cleared = !tripped && was;
		r.tripped_mask = tmask;
		r.reset_mask = rmask;
		return r;
	endfunction

	task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	// watch the ports, compare results in order, track register writes, then predict new samples
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pickup = 16'd100;
			tms = 16'd102;
			op_min = 16'd200;
			op_max = 16'd800;
			op_delay = 16'd100;
			rst_delay = 16'd500;
			for (int c = 0; c < CHANNELS; c++) begin
				progress[c] = '0;
				below_ms[c] = '0;
			end
			tripped = 1'b0;
			expected_results.delete();
			errors = 0;
			trips_seen = 0;
			resets_seen = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%t: unexpected result request, expected none, actual %h",
						$realtime, result);
					errors++;
				end else begin
					want = expected_results.pop_front();
					report_field("trip_active", want.trip_active, result.trip_active);
					report_field("trip_set", want.trip_set, result.trip_set);
					report_field("trip_cleared", want.trip_cleared, result.trip_cleared);
					report_field("tripped_mask", want.tripped_mask, result.tripped_mask);
					report_field("reset_mask", want.reset_mask, result.reset_mask);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PICKUP:      pickup = cfg_data;
					REG_TIME_MULT:   tms = cfg_data;
					REG_MIN_OPERATE: op_min = cfg_data;
					REG_MAX_OPERATE: op_max = cfg_data;
					REG_OP_DELAY:    op_delay = cfg_data;
					REG_RESET_DELAY: rst_delay = cfg_data;
					default: ;
				endcase
			end
			if (sample_valid && sample_ready) begin
				want = predict_trip(sample);
				if (want.trip_set)
					trips_seen++;
				if (want.reset_mask != 0)
					resets_seen++;
				expected_results.push_back(want);
			end
		end
		pending = expected_results.size();
	end

endmodule

### dv/tb_top.sv
// top of the overcurrent trip testbench: clock, reset, stimulus, register phases and verdict
// depends on itot_pkg, itot_checker and the inverse_time_overcurrent_trip rtl
module tb_top;
	import itot_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int PHASE_ITEMS = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid;
	logic        sample_ready;
	sample_t     sample;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          errors, pending, trips_seen, resets_seen;
	int          items_sent = 0;
	int          phases_run = 0;
	logic [15:0] pick_now = 16'd100;
	bit          quiet = 1'b0;

	always #2 clk = ~clk;

	inverse_time_overcurrent_trip i_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	itot_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .trips_seen(trips_seen),
		.resets_seen(resets_seen)
	);

	// result side stalls at random unless quiet
	always @(posedge clk) begin
		result_ready <= quiet || ($urandom_range(99) >= 19);
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// one sample request, optionally after an idle gap
	task automatic send_sample(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
		logic [15:0] c3, logic [15:0] dt);
		if (!quiet && $urandom_range(99) < 19) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{current_ch0: c0, current_ch1: c1, current_ch2: c2,
			current_ch3: c3, elapsed_ms: dt};
		do @(posedge clk); while (!sample_ready);
		items_sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// let the block drain before touching registers or ending
	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_phase(logic [15:0] pk, logic [15:0] tm, logic [15:0] mn,
		logic [15:0] mx, logic [15:0] od, logic [15:0] rd);
		drain();
		write_reg(REG_PICKUP, pk);
		write_reg(REG_TIME_MULT, tm);
		write_reg(REG_MIN_OPERATE, mn);
		write_reg(REG_MAX_OPERATE, mx);
		write_reg(REG_OP_DELAY, od);
		write_reg(REG_RESET_DELAY, rd);
		pick_now = pk;
		phases_run++;
	endtask

	// current relative to pickup: healthy or faulted, with some noise
	function automatic logic [15:0] pick_current(bit fault);
		int unsigned p;
		int unsigned v;
		p = (pick_now == 0) ? 1 : pick_now;
		if ($urandom_range(9) == 0)
			return 16'($urandom());
		if (!fault || $urandom_range(4) == 0)
			return 16'($urandom_range(p));
		case ($urandom_range(2))
			0: v = p + 1 + $urandom_range(p / 50 + 1);
			1: v = p + 1 + $urandom_range(4 * p);
			default: v = p + 1 + $urandom_range(65535);
		endcase
		return (v > 65535) ? 16'hffff : 16'(v);
	endfunction

	function automatic logic [15:0] pick_delta();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return 16'd0;
		if (r < 10)
			return 16'($urandom());
		if (r < 30)
			return 16'($urandom_range(600, 60));
		return 16'($urandom_range(60));
	endfunction

	// fault bursts alternating with healthy stretches
	task automatic random_run(int count);
		bit fault;
		int burst;
		fault = 1'b0;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				fault = !fault;
				burst = $urandom_range(20, 3);
			end
			burst--;
			send_sample(pick_current(fault), pick_current(fault), pick_current(fault),
				pick_current(fault), pick_delta());
		end
	endtask

	initial begin
		sample_valid <= 1'b0;
		sample <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PICKUP;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, pickup boundary, trip then reset, zero delta
		send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_sample(16'd100, 16'd100, 16'd100, 16'd100, 16'd1000);
		send_sample(16'd101, 16'd102, 16'd150, 16'd1000, 16'd50);
		send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0);
		send_sample(16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff);
		send_sample(16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff);
		send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd499);
		send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
		send_sample(16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd300);
		send_sample(16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd300);
		send_sample(16'd5000, 16'd0, 16'd0, 16'd0, 16'hffff);
		send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'hffff);
		send_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
		send_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		random_run(PHASE_ITEMS);

		// register extremes; the spare indexes must be ignored
		set_phase(16'd1, 16'hffff, 16'd0, 16'hffff, 16'hffff, 16'd0);
		write_reg(REG_SPARE_LO, 16'hffff);
		write_reg(REG_SPARE_HI, 16'd0);
		random_run(PHASE_ITEMS);
		// zero pickup, zero dial, max below min down to zero operate time
		set_phase(16'd0, 16'd0, 16'hffff, 16'd0, 16'd0, 16'hffff);
		random_run(PHASE_ITEMS);
		set_phase(16'hffff, 16'd1024, 16'd5000, 16'd300, 16'd20, 16'd1);
		random_run(PHASE_ITEMS / 2);
		set_phase(16'd1000, 16'd1024, 16'd50, 16'd2000, 16'd20, 16'd300);
		quiet = 1'b1;
		random_run(PHASE_ITEMS);
		quiet = 1'b0;
		set_phase(16'd100, 16'd102, 16'd200, 16'd800, 16'd100, 16'd500);
		random_run(PHASE_ITEMS);
		drain();

		$display("%0d sample sets in %0d register settings, %0d trip edges, %0d resets",
			items_sent, phases_run + 1, trips_seen, resets_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### inverse_time_overcurrent_trip.f
src/itot_pkg.sv
src/itot_div.sv
src/itot_queue.sv
src/itot_front.sv
src/itot_back.sv
src/inverse_time_overcurrent_trip.sv
dv/itot_checker.sv
dv/tb_top.sv
